>>> sv/skpq_pkg.sv
// Shared types and codes for the selectable key priority queue.
package skpq_pkg;

  typedef enum logic [1:0] {
    FUNC_ENQ  = 2'd0,
    FUNC_DEQ  = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NOP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    MODE_ARRIVE   = 3'd0,
    MODE_JOB      = 3'd1,
    MODE_LAST     = 3'd2,
    MODE_PAGES    = 3'd3,
    MODE_COMPLETE = 3'd4
  } mode_t;

  typedef struct packed {
    func_t       func;
    logic [15:0] process_id;
    logic [15:0] entry_tag;
    logic [31:0] arrival_cycle;
    logic [31:0] job_cycles;
    logic [31:0] last_exec_time;
    logic [31:0] pages_in_mem;
    logic [31:0] finish_cycle;
    logic [5:0]  position;
  } in_req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] out_process_id;
    logic [15:0] out_tag;
    logic [31:0] out_key;
    logic [6:0]  occupancy;
  } out_rsp_t;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] pid;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

endpackage

>>> sv/skpq_cell.sv
// One queue slot: compares against the incoming entry and shifts with its neighbors.
module skpq_cell import skpq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      slot_valid,
  input  entry_t    new_ent,
  input  entry_t    prev_ent,
  input  logic      prev_le,
  input  entry_t    next_ent,
  output entry_t    ent,
  output logic      le
);

  entry_t ent_r;
  entry_t ent_nxt;

  assign le = slot_valid &&
              ((ent_r.key < new_ent.key) ||
               ((ent_r.key == new_ent.key) && (ent_r.pid <= new_ent.pid)));

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.enq) begin
      if (le) begin
        ent_nxt = ent_r;
      end else if (prev_le) begin
        ent_nxt = new_ent;
      end else begin
        ent_nxt = prev_ent;
      end
    end else if (ctl.deq) begin
      ent_nxt = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

>>> sv/selectable_key_priority_queue_unit.sv
// Top level of the selectable key priority queue: cell chain, count and result register.
// An accepted request's result is registered into the output register in the cycle after it is taken.
// Throughput: one request per cycle while in_stall is low; enqueue compares all cells in
// parallel and the chain shifts in the same edge that accepts the request.
// Reset: synchronous, active low; clears the count, the result valid and the key
// select. Slot contents are not cleared and are read only below the count.
module selectable_key_priority_queue_unit import skpq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [2:0] cfg_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

  logic [2:0]       mode_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_rsp_t         out_data_r;
  out_rsp_t         rsp;

  logic             acc;
  logic             enq_ok;
  logic             deq_ok;
  logic             pos_ok;
  logic [CMP_W-1:0] pos_ext;
  logic [IDX_W-1:0] rd_idx;
  cell_ctl_t        ctl;
  entry_t           new_ent;
  entry_t           cell_ent [DEPTH];
  logic             cell_le  [DEPTH];

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    case (mode_r)
      MODE_JOB:      new_ent.key = in_data.job_cycles;
      MODE_LAST:     new_ent.key = in_data.last_exec_time;
      MODE_PAGES:    new_ent.key = in_data.pages_in_mem;
      MODE_COMPLETE: new_ent.key = in_data.finish_cycle;
      default:       new_ent.key = in_data.arrival_cycle;
    endcase
    new_ent.pid = in_data.process_id;
    new_ent.tag = in_data.entry_tag;
  end

  assign enq_ok  = acc && (in_data.func == FUNC_ENQ) && (count_r != CNT_W'(DEPTH));
  assign deq_ok  = acc && (in_data.func == FUNC_DEQ) && (count_r != '0);
  assign pos_ext = CMP_W'(in_data.position);
  assign pos_ok  = pos_ext < CMP_W'(count_r);
  assign rd_idx  = pos_ext[IDX_W-1:0];
  assign ctl.enq = enq_ok;
  assign ctl.deq = deq_ok;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    skpq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .slot_valid (CNT_W'(i) < count_r),
      .new_ent    (new_ent),
      .prev_ent   ((i == 0) ? new_ent : cell_ent[(i == 0) ? 0 : i - 1]),
      .prev_le    ((i == 0) ? 1'b1 : cell_le[(i == 0) ? 0 : i - 1]),
      .next_ent   (cell_ent[(i == DEPTH - 1) ? i : i + 1]),
      .ent        (cell_ent[i]),
      .le         (cell_le[i])
    );
  end

  always_comb begin
    count_nxt          = count_r;
    rsp.status         = ST_OK;
    rsp.out_process_id = '0;
    rsp.out_tag        = '0;
    rsp.out_key        = '0;
    unique case (in_data.func)
      FUNC_ENQ: begin
        if (enq_ok) begin
          count_nxt = count_r + 1'b1;
        end else begin
          rsp.status = ST_FULL;
        end
      end
      FUNC_DEQ: begin
        if (deq_ok) begin
          count_nxt          = count_r - 1'b1;
          rsp.out_process_id = cell_ent[0].pid;
          rsp.out_tag        = cell_ent[0].tag;
          rsp.out_key        = cell_ent[0].key;
        end else begin
          rsp.status = ST_EMPTY;
        end
      end
      FUNC_READ: begin
        if (pos_ok) begin
          rsp.out_process_id = cell_ent[rd_idx].pid;
          rsp.out_tag        = cell_ent[rd_idx].tag;
          rsp.out_key        = cell_ent[rd_idx].key;
        end else begin
          rsp.status = ST_RANGE;
        end
      end
      default: begin
        rsp.status = ST_OK;
      end
    endcase
    rsp.occupancy = 7'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_ARRIVE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      if (acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= rsp;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    enq_ok |=> count_r == $past(count_r) + 1'b1)
    else $error("enqueue did not advance count");

  a_deq_head: assert property (@(posedge clk) disable iff (!rst_n)
    deq_ok |=> out_data_r.out_key == $past(cell_ent[0].key) &&
               out_data_r.out_process_id == $past(cell_ent[0].pid))
    else $error("dequeue result is not the head entry");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(2) |-> cell_ent[0].key <= cell_ent[1].key)
    else $error("head entries out of order");

endmodule
